/* rtl/ac3_mdct_block_switched_macros.svh */
// Assertion helpers shared by the checking code of the transform block.
`ifndef AC3_MDCT_BLOCK_SWITCHED_MACROS_SVH
`define AC3_MDCT_BLOCK_SWITCHED_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define AC3M_ASSERT_IMPLIES(name, cond, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define AC3M_ASSERT_NEXT(name, cond, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

/* rtl/ac3m_pkg.sv */
package ac3m_pkg;

    localparam int BLOCK_LEN     = 512;
    localparam int HALF_LEN      = BLOCK_LEN / 2;
    localparam int QUARTER_LEN   = BLOCK_LEN / 4;
    localparam int SAMPLE_W      = 24;
    localparam int TW_W          = 18;
    localparam int WORK_W        = 28;
    localparam int TF            = TW_W - 1;
    localparam int SF            = SAMPLE_W - 1;
    localparam int WF            = WORK_W - 2;
    localparam int PRE_SHIFT     = SF + TF + 1 - WF;
    localparam int BF_SHIFT      = TF + 1;
    localparam int POST_SHIFT    = WF + TF - SF;
    localparam int SAMPLE_ADDR_W = $clog2(BLOCK_LEN);
    localparam int COEF_ADDR_W   = $clog2(HALF_LEN);
    localparam int WORK_DEPTH    = QUARTER_LEN;
    localparam int WORK_ADDR_W   = $clog2(WORK_DEPTH);
    localparam int ROT_DEPTH     = QUARTER_LEN + QUARTER_LEN / 2;
    localparam int ROT_ADDR_W    = $clog2(ROT_DEPTH);
    localparam int TW_DEPTH      = WORK_DEPTH / 2;
    localparam int TW_ADDR_W     = $clog2(TW_DEPTH);
    localparam int TW_QUARTER    = TW_DEPTH / 2;
    localparam int OPA_W         = WORK_W;
    localparam int OPB_W         = TW_W + 1;
    localparam int PROD_W        = OPA_W + OPB_W;
    localparam int ACC_W         = PROD_W + 3;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);

    localparam logic [COEF_ADDR_W-1:0] COEF_LAST = COEF_ADDR_W'(HALF_LEN - 1);
    localparam logic signed [OPB_W-1:0] TW_UNIT = OPB_W'(1 << TF);

    localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;
    localparam longint unsigned Q30_HALF   = 64'd1 << 29;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       short_block;
    } item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] coefficient;
        logic [COEF_ADDR_W-1:0]     coef_index;
        logic                       last;
    } result_t;

    typedef struct packed {
        logic                       en;
        logic [COEF_ADDR_W-1:0]     addr;
        logic signed [SAMPLE_W-1:0] data;
    } coef_wr_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

    typedef struct packed {
        logic signed [TW_W-1:0] c;
        logic signed [TW_W-1:0] s;
    } cs_t;

    typedef cs_t [ROT_DEPTH-1:0] rot_rom_t;
    typedef cs_t [TW_DEPTH-1:0]  tw_rom_t;

    // shift and subtract long division, only used while building the tables
    function automatic longint unsigned udiv64(input longint unsigned num,
                                               input longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[62:0], num[b]};
            if (rem >= den)
            begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic longint to_twiddle(input longint unsigned q30);
        longint unsigned m;
        longint unsigned cap;
        m   = (q30 + (64'd1 << (29 - TF))) >> (30 - TF);
        cap = (64'd1 << TF) - 64'd1;
        return longint'((m > cap) ? cap : m);
    endfunction

    // cosine and sine of 2*pi*m/4096 from a Taylor series on the first octant
    function automatic cs_t trig_entry(input int unsigned m);
        int unsigned     q;
        int unsigned     r;
        logic            swap;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned tc;
        longint unsigned ts;
        longint          cq;
        longint          sq;
        longint          c;
        longint          s;
        longint          t;
        cs_t             res;
        q    = (m >> 10) & 3;
        r    = m & 1023;
        swap = (r > 512);
        if (swap)
        begin
            r = 1024 - r;
        end
        x  = (longint'(r) * TWO_PI_Q30 + 64'd2048) >> 12;
        x2 = (x * x + Q30_HALF) >> 30;
        tc = 64'd1 << 30;
        ts = x;
        cq = longint'(tc);
        sq = longint'(ts);
        for (int k = 1; k <= 6; k++)
        begin
            tc = udiv64((tc * x2 + Q30_HALF) >> 30, longint'((2 * k - 1) * (2 * k)));
            ts = udiv64((ts * x2 + Q30_HALF) >> 30, longint'((2 * k) * (2 * k + 1)));
            if ((k & 1) == 1)
            begin
                cq = cq - longint'(tc);
                sq = sq - longint'(ts);
            end
            else
            begin
                cq = cq + longint'(tc);
                sq = sq + longint'(ts);
            end
        end
        c = to_twiddle((cq < 0) ? 64'd0 : longint'(cq));
        s = to_twiddle((sq < 0) ? 64'd0 : longint'(sq));
        if (swap)
        begin
            t = c;
            c = s;
            s = t;
        end
        case (q)
            0:       begin res.c = TW_W'(c);  res.s = TW_W'(s);  end
            1:       begin res.c = TW_W'(-s); res.s = TW_W'(c);  end
            2:       begin res.c = TW_W'(-c); res.s = TW_W'(-s); end
            default: begin res.c = TW_W'(s);  res.s = TW_W'(-c); end
        endcase
        return res;
    endfunction

    function automatic rot_rom_t build_rotation_rom();
        rot_rom_t rom;
        cs_t      p;
        for (int i = 0; i < QUARTER_LEN; i++)
        begin
            p         = trig_entry(8 * i + 1);
            rom[i].c  = -p.c;
            rom[i].s  = -p.s;
        end
        for (int i = 0; i < QUARTER_LEN / 2; i++)
        begin
            p                      = trig_entry(16 * i + 2);
            rom[QUARTER_LEN + i].c = -p.c;
            rom[QUARTER_LEN + i].s = -p.s;
        end
        return rom;
    endfunction

    function automatic tw_rom_t build_twiddle_rom();
        tw_rom_t rom;
        for (int i = 0; i < TW_DEPTH; i++)
        begin
            rom[i] = trig_entry(32 * i);
        end
        return rom;
    endfunction

    // round half up at bit sh, then clamp to a signed range of the given width
    function automatic logic signed [ACC_W-1:0] round_sat(input logic signed [ACC_W-1:0] v,
                                                         input int sh, input int bits);
        logic signed [ACC_W-1:0] half;
        logic signed [ACC_W-1:0] r;
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        half         = '0;
        half[sh - 1] = 1'b1;
        r            = (v + half) >>> sh;
        hi           = '0;
        hi[bits - 1] = 1'b1;
        hi           = hi - 1;
        lo           = -hi - 1;
        if (r > hi)
        begin
            return hi;
        end
        if (r < lo)
        begin
            return lo;
        end
        return r;
    endfunction

endpackage

/* rtl/ac3m_queue.sv */
module ac3m_queue import ac3m_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic          push_mode,
    input  logic          pop,
    output logic          head_mode,
    output queue_status_t status
);

    logic [QUEUE_DEPTH-1:0]  mode_reg;
    logic [QUEUE_PTR_W-1:0]  wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0]  rd_ptr_reg;
    logic [QUEUE_PTR_W:0]    count_reg;
    logic [QUEUE_PTR_W:0]    count_next;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
    assign head_mode    = mode_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                mode_reg[wr_ptr_reg] <= push_mode;
                wr_ptr_reg           <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

/* rtl/ac3m_front.sv */
module ac3m_front import ac3m_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic                       busy,
    input  item_t                      item,
    output result_t                    result,
    output logic                       strobe,
    output logic                       push,
    output logic                       push_mode,
    input  logic [SAMPLE_ADDR_W-1:0]   sample_addr,
    output logic signed [SAMPLE_W-1:0] sample_data,
    input  coef_wr_t                   coef_wr
);

    logic                       accept;
    logic                       emit;
    logic                       block_end;
    logic [SAMPLE_ADDR_W-1:0]   count_reg;
    logic [SAMPLE_ADDR_W-1:0]   count_next;
    logic                       mode_reg;
    logic                       ready_reg;
    logic                       strobe_reg;
    logic [COEF_ADDR_W-1:0]     index_reg;
    logic                       last_reg;
    logic signed [SAMPLE_W-1:0] coef_rd_reg;
    logic signed [SAMPLE_W-1:0] sample_rd_reg;
    logic signed [SAMPLE_W-1:0] sample_mem [BLOCK_LEN];
    logic signed [SAMPLE_W-1:0] coef_mem [HALF_LEN];

    assign accept     = start && !busy;
    assign emit       = accept && ready_reg && (count_reg < SAMPLE_ADDR_W'(HALF_LEN));
    assign block_end  = (count_reg == SAMPLE_ADDR_W'(BLOCK_LEN - 1));
    assign count_next = count_reg + 1'b1;
    assign push       = accept && block_end;
    assign push_mode  = mode_reg;

    assign strobe             = strobe_reg;
    assign result.coefficient = coef_rd_reg;
    assign result.coef_index  = index_reg;
    assign result.last        = last_reg;
    assign sample_data        = sample_rd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            mode_reg   <= 1'b0;
            ready_reg  <= 1'b0;
            strobe_reg <= 1'b0;
            index_reg  <= '0;
            last_reg   <= 1'b0;
        end
        else
        begin
            strobe_reg <= emit;
            if (emit)
            begin
                index_reg <= count_reg[COEF_ADDR_W-1:0];
                last_reg  <= (count_reg[COEF_ADDR_W-1:0] == COEF_LAST);
                if (count_reg[COEF_ADDR_W-1:0] == COEF_LAST)
                begin
                    ready_reg <= 1'b0;
                end
            end
            if (accept)
            begin
                if (count_reg == '0)
                begin
                    mode_reg <= item.short_block;
                end
                // coefficients of this block are ready once the transform drains
                if (block_end)
                begin
                    ready_reg <= 1'b1;
                end
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_mem[count_reg] <= item.sample;
            coef_rd_reg           <= coef_mem[count_reg[COEF_ADDR_W-1:0]];
        end
        sample_rd_reg <= sample_mem[sample_addr];
        if (coef_wr.en)
        begin
            coef_mem[coef_wr.addr] <= coef_wr.data;
        end
    end

endmodule

/* rtl/ac3m_back.sv */
module ac3m_back import ac3m_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       job_valid,
    input  logic                       job_mode,
    output logic                       job_pop,
    output logic                       active,
    output logic [SAMPLE_ADDR_W-1:0]   sample_addr,
    input  logic signed [SAMPLE_W-1:0] sample_data,
    output coef_wr_t                   coef_wr
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_PRE_RD,
        S_PRE_OP,
        S_PRE_MUL,
        S_PRE_WR,
        S_BF_RD0,
        S_BF_RD1,
        S_BF_RD2,
        S_BF_MUL,
        S_BF_WP,
        S_BF_WQ,
        S_POST_RD0,
        S_POST_RD1,
        S_POST_MUL,
        S_POST_W1,
        S_POST_W2
    } state_t;

    localparam rot_rom_t ROT_ROM = build_rotation_rom();
    localparam tw_rom_t  TW_ROM  = build_twiddle_rom();

    function automatic logic [WORK_ADDR_W-1:0] bit_rev(input logic [WORK_ADDR_W-1:0] v);
        logic [WORK_ADDR_W-1:0] r;
        for (int b = 0; b < WORK_ADDR_W; b++)
        begin
            r[b] = v[WORK_ADDR_W - 1 - b];
        end
        return r;
    endfunction

    state_t                   state_reg;
    logic                     short_reg;
    logic                     half_reg;
    logic [WORK_ADDR_W-1:0]   idx_reg;
    logic [2:0]               stage_reg;
    logic [2:0]               rcnt_reg;

    logic                     neg_reg;
    logic signed [SAMPLE_W:0] x_reg [4];
    logic signed [OPA_W-1:0]  opx_reg;
    logic signed [OPA_W-1:0]  opy_reg;
    logic signed [OPB_W-1:0]  opc_reg;
    logic signed [OPB_W-1:0]  ops_reg;
    logic signed [PROD_W-1:0] p1_reg;
    logic signed [PROD_W-1:0] p2_reg;
    logic signed [PROD_W-1:0] p3_reg;
    logic signed [PROD_W-1:0] p4_reg;
    logic signed [WORK_W-1:0] pr_reg;
    logic signed [WORK_W-1:0] pi_reg;

    logic [2*WORK_W-1:0]      work_mem [WORK_DEPTH];
    logic [2*WORK_W-1:0]      work_rd_reg;
    logic                     work_we;
    logic [WORK_ADDR_W-1:0]   work_wa;
    logic [WORK_ADDR_W-1:0]   work_ra;
    logic [2*WORK_W-1:0]      work_wd;

    logic [WORK_ADDR_W-1:0]   last_idx;
    logic [WORK_ADDR_W-1:0]   last_bf;
    logic [2:0]               last_stage;
    logic [ROT_ADDR_W-1:0]    rot_addr;
    cs_t                      rot_cs;
    logic [SAMPLE_ADDR_W-1:0] two_i;
    logic [SAMPLE_ADDR_W-1:0] elem;
    logic [SAMPLE_ADDR_W-1:0] n_len;
    logic [SAMPLE_ADDR_W-1:0] n_half;
    logic                     map_neg;
    logic [WORK_ADDR_W-1:0]   hmask;
    logic [WORK_ADDR_W-1:0]   bf_p;
    logic [WORK_ADDR_W-1:0]   bf_q;
    logic [WORK_ADDR_W-1:0]   tw_shift;
    logic [TW_ADDR_W-1:0]     tw_addr;
    logic signed [OPB_W-1:0]  tw_c;
    logic signed [OPB_W-1:0]  tw_s;
    logic [WORK_ADDR_W-1:0]   pre_wa;
    logic signed [SAMPLE_W:0] samp_ext;
    logic signed [SAMPLE_W+1:0] diff_a;
    logic signed [SAMPLE_W+1:0] diff_b;
    logic [1:0]               x_sel;

    logic signed [ACC_W-1:0]  p1e;
    logic signed [ACC_W-1:0]  p2e;
    logic signed [ACC_W-1:0]  p3e;
    logic signed [ACC_W-1:0]  p4e;
    logic signed [ACC_W-1:0]  prs;
    logic signed [ACC_W-1:0]  pis;
    logic signed [ACC_W-1:0]  tr;
    logic signed [ACC_W-1:0]  ti;
    logic signed [ACC_W-1:0]  pre_re;
    logic signed [ACC_W-1:0]  pre_im;
    logic signed [ACC_W-1:0]  bfp_re;
    logic signed [ACC_W-1:0]  bfp_im;
    logic signed [ACC_W-1:0]  bfq_re;
    logic signed [ACC_W-1:0]  bfq_im;
    logic signed [ACC_W-1:0]  post_a;
    logic signed [ACC_W-1:0]  post_b;
    logic [COEF_ADDR_W-1:0]   dst;

    assign job_pop = (state_reg == S_IDLE) && job_valid;
    assign active  = (state_reg != S_IDLE);

    assign last_idx   = short_reg ? WORK_ADDR_W'(WORK_DEPTH / 2 - 1) : WORK_ADDR_W'(WORK_DEPTH - 1);
    assign last_bf    = short_reg ? WORK_ADDR_W'(WORK_DEPTH / 4 - 1) : WORK_ADDR_W'(WORK_DEPTH / 2 - 1);
    assign last_stage = short_reg ? 3'(WORK_ADDR_W - 2) : 3'(WORK_ADDR_W - 1);

    assign rot_addr = short_reg ? ROT_ADDR_W'(QUARTER_LEN + idx_reg[WORK_ADDR_W-2:0])
                                : ROT_ADDR_W'(idx_reg);
    assign rot_cs   = ROT_ROM[rot_addr];

    // index into the rotated block for each of the four pre-rotation operands
    assign two_i  = SAMPLE_ADDR_W'({idx_reg, 1'b0});
    assign n_len  = short_reg ? SAMPLE_ADDR_W'(HALF_LEN) : SAMPLE_ADDR_W'(BLOCK_LEN);
    assign n_half = short_reg ? SAMPLE_ADDR_W'(QUARTER_LEN) : SAMPLE_ADDR_W'(HALF_LEN);

    always_comb
    begin
        case (rcnt_reg[1:0])
            2'd0:    elem = two_i;
            2'd1:    elem = n_len - 1'b1 - two_i;
            2'd2:    elem = n_half + two_i;
            default: elem = n_half - 1'b1 - two_i;
        endcase
        map_neg     = 1'b0;
        sample_addr = elem;
        if (!short_reg || half_reg)
        begin
            if (elem < SAMPLE_ADDR_W'(QUARTER_LEN))
            begin
                map_neg     = 1'b1;
                sample_addr = elem + SAMPLE_ADDR_W'(BLOCK_LEN - QUARTER_LEN);
            end
            else if (short_reg)
            begin
                sample_addr = elem + SAMPLE_ADDR_W'(QUARTER_LEN);
            end
            else
            begin
                sample_addr = elem - SAMPLE_ADDR_W'(QUARTER_LEN);
            end
        end
    end

    assign samp_ext = (SAMPLE_W + 1)'(sample_data);
    assign x_sel    = 2'(rcnt_reg - 3'd1);
    assign diff_a   = x_reg[0] - x_reg[1];
    assign diff_b   = x_reg[2] - x_reg[3];
    assign pre_wa   = bit_rev(short_reg ? {idx_reg[WORK_ADDR_W-2:0], 1'b0} : idx_reg);

    // butterfly pair and twiddle address for this stage
    assign hmask    = (WORK_ADDR_W'(1) << stage_reg) - 1'b1;
    assign bf_p     = ((idx_reg & ~hmask) << 1) | (idx_reg & hmask);
    assign bf_q     = bf_p | (WORK_ADDR_W'(1) << stage_reg);
    assign tw_shift = (idx_reg & hmask) << (3'(WORK_ADDR_W - 1) - stage_reg);
    assign tw_addr  = tw_shift[TW_ADDR_W-1:0];

    always_comb
    begin
        if (tw_addr == '0)
        begin
            tw_c = TW_UNIT;
            tw_s = '0;
        end
        else if (tw_addr == TW_ADDR_W'(TW_QUARTER))
        begin
            tw_c = '0;
            tw_s = TW_UNIT;
        end
        else
        begin
            tw_c = OPB_W'(TW_ROM[tw_addr].c);
            tw_s = OPB_W'(TW_ROM[tw_addr].s);
        end
    end

    assign p1e = ACC_W'(p1_reg);
    assign p2e = ACC_W'(p2_reg);
    assign p3e = ACC_W'(p3_reg);
    assign p4e = ACC_W'(p4_reg);
    assign prs = ACC_W'(pr_reg) <<< TF;
    assign pis = ACC_W'(pi_reg) <<< TF;
    assign tr  = p1e + p2e;
    assign ti  = p3e - p4e;

    assign pre_re = round_sat(p2e - p1e, PRE_SHIFT, WORK_W);
    assign pre_im = round_sat(p4e + p3e, PRE_SHIFT, WORK_W);
    assign bfp_re = round_sat(prs + tr, BF_SHIFT, WORK_W);
    assign bfp_im = round_sat(pis + ti, BF_SHIFT, WORK_W);
    assign bfq_re = round_sat(prs - tr, BF_SHIFT, WORK_W);
    assign bfq_im = round_sat(pis - ti, BF_SHIFT, WORK_W);
    assign post_a = round_sat(p4e - p3e, POST_SHIFT, SAMPLE_W);
    assign post_b = round_sat(p1e + p2e, POST_SHIFT, SAMPLE_W);

    always_comb
    begin
        work_we = 1'b0;
        work_wa = bf_p;
        work_wd = {bfp_re[WORK_W-1:0], bfp_im[WORK_W-1:0]};
        work_ra = bf_p;
        dst     = '0;
        coef_wr = '0;
        case (state_reg)
            S_PRE_WR:
            begin
                work_we = 1'b1;
                work_wa = pre_wa;
                work_wd = {pre_re[WORK_W-1:0], pre_im[WORK_W-1:0]};
            end
            S_BF_WP:
            begin
                work_we = 1'b1;
            end
            S_BF_WQ:
            begin
                work_we = 1'b1;
                work_wa = bf_q;
                work_wd = {bfq_re[WORK_W-1:0], bfq_im[WORK_W-1:0]};
            end
            S_BF_RD1:
            begin
                work_ra = bf_q;
            end
            S_POST_RD0:
            begin
                work_ra = idx_reg;
            end
            S_POST_W1:
            begin
                dst          = (short_reg ? COEF_ADDR_W'(QUARTER_LEN - 1) : COEF_LAST)
                               - COEF_ADDR_W'({idx_reg, 1'b0});
                coef_wr.en   = 1'b1;
                coef_wr.data = post_a[SAMPLE_W-1:0];
            end
            S_POST_W2:
            begin
                dst          = COEF_ADDR_W'({idx_reg, 1'b0});
                coef_wr.en   = 1'b1;
                coef_wr.data = post_b[SAMPLE_W-1:0];
            end
            default:
            begin
                work_we = 1'b0;
            end
        endcase
        // short blocks interleave the two half transforms
        coef_wr.addr = short_reg ? {dst[COEF_ADDR_W-2:0], half_reg} : dst;
    end

    always_ff @(posedge clk)
    begin
        if (work_we)
        begin
            work_mem[work_wa] <= work_wd;
        end
        work_rd_reg <= work_mem[work_ra];
    end

    always_ff @(posedge clk)
    begin
        p1_reg  <= opx_reg * opc_reg;
        p2_reg  <= opy_reg * ops_reg;
        p3_reg  <= opy_reg * opc_reg;
        p4_reg  <= opx_reg * ops_reg;
        neg_reg <= map_neg;
        case (state_reg)
            S_PRE_RD:
            begin
                if (rcnt_reg != '0)
                begin
                    x_reg[x_sel] <= neg_reg ? -samp_ext : samp_ext;
                end
            end
            S_PRE_OP:
            begin
                opx_reg <= OPA_W'(diff_a);
                opy_reg <= OPA_W'(diff_b);
                opc_reg <= OPB_W'(rot_cs.c);
                ops_reg <= OPB_W'(rot_cs.s);
            end
            S_BF_RD1:
            begin
                pr_reg <= $signed(work_rd_reg[2*WORK_W-1:WORK_W]);
                pi_reg <= $signed(work_rd_reg[WORK_W-1:0]);
            end
            S_BF_RD2:
            begin
                opx_reg <= $signed(work_rd_reg[2*WORK_W-1:WORK_W]);
                opy_reg <= $signed(work_rd_reg[WORK_W-1:0]);
                opc_reg <= tw_c;
                ops_reg <= tw_s;
            end
            S_POST_RD1:
            begin
                opx_reg <= $signed(work_rd_reg[2*WORK_W-1:WORK_W]);
                opy_reg <= $signed(work_rd_reg[WORK_W-1:0]);
                opc_reg <= OPB_W'(rot_cs.c);
                ops_reg <= OPB_W'(rot_cs.s);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            short_reg <= 1'b0;
            half_reg  <= 1'b0;
            idx_reg   <= '0;
            stage_reg <= '0;
            rcnt_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (job_valid)
                    begin
                        short_reg <= job_mode;
                        half_reg  <= 1'b0;
                        idx_reg   <= '0;
                        rcnt_reg  <= '0;
                        state_reg <= S_PRE_RD;
                    end
                end
                S_PRE_RD:
                begin
                    if (rcnt_reg == 3'd4)
                    begin
                        rcnt_reg  <= '0;
                        state_reg <= S_PRE_OP;
                    end
                    else
                    begin
                        rcnt_reg <= rcnt_reg + 1'b1;
                    end
                end
                S_PRE_OP:
                begin
                    state_reg <= S_PRE_MUL;
                end
                S_PRE_MUL:
                begin
                    state_reg <= S_PRE_WR;
                end
                S_PRE_WR:
                begin
                    if (idx_reg == last_idx)
                    begin
                        idx_reg   <= '0;
                        stage_reg <= '0;
                        state_reg <= S_BF_RD0;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_PRE_RD;
                    end
                end
                S_BF_RD0:
                begin
                    state_reg <= S_BF_RD1;
                end
                S_BF_RD1:
                begin
                    state_reg <= S_BF_RD2;
                end
                S_BF_RD2:
                begin
                    state_reg <= S_BF_MUL;
                end
                S_BF_MUL:
                begin
                    state_reg <= S_BF_WP;
                end
                S_BF_WP:
                begin
                    state_reg <= S_BF_WQ;
                end
                S_BF_WQ:
                begin
                    if (idx_reg == last_bf)
                    begin
                        idx_reg <= '0;
                        if (stage_reg == last_stage)
                        begin
                            state_reg <= S_POST_RD0;
                        end
                        else
                        begin
                            stage_reg <= stage_reg + 1'b1;
                            state_reg <= S_BF_RD0;
                        end
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_BF_RD0;
                    end
                end
                S_POST_RD0:
                begin
                    state_reg <= S_POST_RD1;
                end
                S_POST_RD1:
                begin
                    state_reg <= S_POST_MUL;
                end
                S_POST_MUL:
                begin
                    state_reg <= S_POST_W1;
                end
                S_POST_W1:
                begin
                    state_reg <= S_POST_W2;
                end
                S_POST_W2:
                begin
                    if (idx_reg == last_idx)
                    begin
                        idx_reg <= '0;
                        if (short_reg && !half_reg)
                        begin
                            half_reg  <= 1'b1;
                            rcnt_reg  <= '0;
                            state_reg <= S_PRE_RD;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_POST_RD0;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* rtl/ac3_mdct_block_switched.sv */
// Block-switched 512-sample MDCT. One sample item is taken per cycle while busy is low.
// After the 512th sample of a block, busy stays high while the transform runs for a long
// block or a pair of short blocks, through a sequencer that runs one rotation or one
// butterfly at a time through the single read port of the 128-entry work memory. Each
// of the first 256 samples of the next block brings out one coefficient of the previous
// block, on result for exactly one cycle with strobe high, the cycle after the sample is
// taken; the receiver cannot stall it. No result comes out for the first block after
// reset.
`include "ac3_mdct_block_switched_macros.svh"

module ac3_mdct_block_switched import ac3m_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  item_t   item,
    output result_t result,
    output logic    strobe
);

    logic                       push;
    logic                       push_mode;
    logic                       head_mode;
    logic                       job_pop;
    logic                       back_active;
    queue_status_t              q_status;
    logic [SAMPLE_ADDR_W-1:0]   sample_addr;
    logic signed [SAMPLE_W-1:0] sample_data;
    coef_wr_t                   coef_wr;

    assign busy = !q_status.empty || back_active;

    ac3m_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .item        (item),
        .result      (result),
        .strobe      (strobe),
        .push        (push),
        .push_mode   (push_mode),
        .sample_addr (sample_addr),
        .sample_data (sample_data),
        .coef_wr     (coef_wr)
    );

    ac3m_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_mode (push_mode),
        .pop       (job_pop),
        .head_mode (head_mode),
        .status    (q_status)
    );

    ac3m_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (!q_status.empty),
        .job_mode    (head_mode),
        .job_pop     (job_pop),
        .active      (back_active),
        .sample_addr (sample_addr),
        .sample_data (sample_data),
        .coef_wr     (coef_wr)
    );

    `AC3M_ASSERT_NEXT(a_strobe_after_accept, !(start && !busy), !strobe, "strobe without an accepted item")
    `AC3M_ASSERT_IMPLIES(a_queue_no_overflow, push, !q_status.full, "job queue overflow")
    `AC3M_ASSERT_IMPLIES(a_no_coef_write_idle, coef_wr.en, back_active, "coefficient write while idle")
    `AC3M_ASSERT_IMPLIES(a_last_at_end, strobe && result.last, result.coef_index == COEF_LAST, "last off end")

endmodule
